### rtl/wve_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wve_pkg: shared types and constants for the wind vector estimator
// Datapath widths, CORDIC arctangent table, gain correction and the
// command/response structs between the sequencer and the CORDIC unit.
// ----------------------------------------------------------------------------
package wve_pkg;

  // CORDIC datapath: x/y are signed, z is a 32-bit binary angle
  localparam int unsigned DW        = 34;
  localparam int unsigned ZW        = 32;
  localparam int unsigned PW        = 66;
  localparam int unsigned TABLE_LEN = 24;
  localparam int unsigned CW        = 5;

  // 1/K in Q30, split in two 16-bit halves for the shared multiplier
  localparam logic [15:0] INV_GAIN_HI = 16'h26DD;
  localparam logic [15:0] INV_GAIN_LO = 16'h3B6A;

  localparam logic [ZW-1:0] Z_HALF_TURN = 32'h8000_0000;
  localparam logic [ZW-1:0] Z_ROUND_16  = 32'h0000_8000;

  // Command into the CORDIC unit
  typedef struct packed {
    logic                 start;
    logic                 vec;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic [ZW-1:0]        z;
  } cordic_cmd_t;

  // Response: x and y already multiplied by 1/K (Q30), final angle
  typedef struct packed {
    logic                 done;
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic [ZW-1:0]        z;
  } cordic_rsp_t;

  // atan(2^-i) in 2^32 units per turn
  function automatic logic [ZW-1:0] atan_lut(input logic [CW-1:0] idx);
    logic [ZW-1:0] v;
    unique case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/wve_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wve_cordic: iterative CORDIC with gain correction
// One micro-rotation per cycle in rotation or vectoring mode, then x and y
// are multiplied by 1/K through one 34x17 multiplier in two half passes each.
// ----------------------------------------------------------------------------
module wve_cordic #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wve_pkg::cordic_cmd_t cmd_i,
  output wve_pkg::cordic_rsp_t rsp_o
);
  import wve_pkg::*;

  localparam int unsigned NumSteps = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam logic [CW-1:0] LastStep = CW'(NumSteps - 1);

  typedef enum logic [5:0] {
    C_IDLE = 6'b000001,
    C_ITER = 6'b000010,
    C_MXH  = 6'b000100,
    C_MXL  = 6'b001000,
    C_MYH  = 6'b010000,
    C_MYL  = 6'b100000
  } cstate_e;

  cstate_e              state_q, state_d;
  logic [CW-1:0]        cnt_q;
  logic                 vec_q;
  logic                 done_q;
  logic signed [DW-1:0] x_q, y_q;
  logic [ZW-1:0]        z_q;
  logic signed [PW-1:0] acc_q, px_q, py_q;

  logic signed [DW-1:0] dx, dy, x_nx, y_nx, op;
  logic [ZW-1:0]        z_nx, atan_v;
  logic                 rot_pos;
  logic [15:0]          coef;
  logic signed [DW+16:0] prod;
  logic signed [PW-1:0] prod_ext, acc_sum;

  // One micro-rotation
  always_comb begin
    dx      = y_q >>> cnt_q;
    dy      = x_q >>> cnt_q;
    atan_v  = atan_lut(cnt_q);
    rot_pos = vec_q ? y_q[DW-1] : !z_q[ZW-1];
    if (rot_pos) begin
      x_nx = x_q - dx;
      y_nx = y_q + dy;
      z_nx = z_q - atan_v;
    end else begin
      x_nx = x_q + dx;
      y_nx = y_q - dy;
      z_nx = z_q + atan_v;
    end
  end

  // Shared gain multiplier: high half first, then shift and add low half
  always_comb begin
    op       = (state_q == C_MYH || state_q == C_MYL) ? y_q : x_q;
    coef     = (state_q == C_MXH || state_q == C_MYH) ? INV_GAIN_HI : INV_GAIN_LO;
    prod     = op * $signed({1'b0, coef});
    prod_ext = {{(PW - DW - 17){prod[DW+16]}}, prod};
    acc_sum  = (acc_q <<< 16) + prod_ext;
  end

  // Sequence the passes
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      C_IDLE:  if (cmd_i.start) state_d = C_ITER;
      C_ITER:  if (cnt_q == LastStep) state_d = C_MXH;
      C_MXH:   state_d = C_MXL;
      C_MXL:   state_d = C_MYH;
      C_MYH:   state_d = C_MYL;
      C_MYL:   state_d = C_IDLE;
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == C_MYL);
      if (state_q == C_IDLE) begin
        cnt_q <= '0;
      end else if (state_q == C_ITER) begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      C_IDLE: begin
        if (cmd_i.start) begin
          x_q   <= cmd_i.x;
          y_q   <= cmd_i.y;
          z_q   <= cmd_i.z;
          vec_q <= cmd_i.vec;
        end
      end
      C_ITER: begin
        x_q <= x_nx;
        y_q <= y_nx;
        z_q <= z_nx;
      end
      C_MXH:   acc_q <= prod_ext;
      C_MXL:   px_q  <= acc_sum;
      C_MYH:   acc_q <= prod_ext;
      C_MYL:   py_q  <= acc_sum;
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.px   = px_q;
  assign rsp_o.py   = py_q;
  assign rsp_o.z    = z_q;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> state_q == C_IDLE)
    else $error("CORDIC started while busy");
  a_iter_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == C_ITER) |-> cnt_q <= LastStep)
    else $error("CORDIC step counter past last step");
  a_done_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == C_MYL))
    else $error("CORDIC done without finishing gain pass");
`endif

endmodule

### rtl/wind_vector_estimator.sv
`timescale 1ns / 1ps
// Each accepted word runs a ground pass and an air pass through the CORDIC, then a
//   vectoring pass on the wind vector, and is then pushed to the output register; the
//   third pass is skipped when the wind vector is zero.
// Input not ready while busy: a new word is taken only after the last one is pushed;
//   a result waits in the output register and stalls the push only if still unread.
// Reset: asynchronous, active low; clears sequencer, output valid and previous parts.
// ----------------------------------------------------------------------------
// wind_vector_estimator: wind triangle estimate from ground and air vectors
// Resolves ground and air vectors into north/east, averages the difference
// with the previous sample and returns wind direction and magnitude.
// ----------------------------------------------------------------------------
module wind_vector_estimator #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // ground_speed[15:0], ground_track[31:16], air_speed[47:32], air_heading[63:48]
  input  logic [63:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // wind_direction[15:0], wind_magnitude[31:16]
  output logic [31:0] m_axis_tdata_o
);
  import wve_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b00000001,
    S_GND_GO  = 8'b00000010,
    S_GND_RUN = 8'b00000100,
    S_AIR_GO  = 8'b00001000,
    S_AIR_RUN = 8'b00010000,
    S_WND_GO  = 8'b00100000,
    S_WND_RUN = 8'b01000000,
    S_PUSH    = 8'b10000000
  } state_e;

  state_e             state_q, state_d;
  logic [63:0]        in_q;
  logic signed [17:0] cur_gn_q, cur_ge_q, cur_an_q, cur_ae_q;
  logic signed [17:0] prev_gn_q, prev_ge_q, prev_an_q, prev_ae_q;
  logic [15:0]        dir_q, mag_q;
  logic [31:0]        out_data_q;
  logic               out_valid_q;

  cordic_cmd_t          cmd;
  cordic_rsp_t          rsp;
  logic                 in_acc, push;
  logic signed [19:0]   dn, de;
  logic                 wind_zero;
  logic signed [PW-1:0] rnd_n, rnd_e, rnd_m;
  logic [ZW-1:0]        dir_rnd;
  logic [15:0]          mag_sat;

  // Start vector for rotation mode: nearest quarter turn, then the residue
  function automatic cordic_cmd_t rot_cmd(input logic [15:0] spd, input logic [15:0] ang);
    cordic_cmd_t          c;
    logic [15:0]          sum;
    logic [1:0]           q;
    logic [15:0]          r;
    logic signed [DW-1:0] s;
    sum     = ang + 16'd8192;
    q       = sum[15:14];
    r       = ang - {q, 14'd0};
    s       = $signed({4'b0, spd, 14'd0});
    c.start = 1'b1;
    c.vec   = 1'b0;
    c.z     = {r, 16'h0000};
    c.x     = q[0] ? '0 : (q[1] ? -s : s);
    c.y     = q[0] ? (q[1] ? -s : s) : '0;
    return c;
  endfunction

  wve_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .rsp_o (rsp)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign push            = (state_q == S_PUSH) && (!out_valid_q || m_axis_tready_i);

  // Twice the wind: current plus previous, ground minus air
  always_comb begin
    dn = (20'(cur_gn_q) + 20'(prev_gn_q)) - (20'(cur_an_q) + 20'(prev_an_q));
    de = (20'(cur_ge_q) + 20'(prev_ge_q)) - (20'(cur_ae_q) + 20'(prev_ae_q));
    wind_zero = (dn == '0) && (de == '0);
  end

  // Issue CORDIC commands
  always_comb begin
    cmd = '0;
    unique case (state_q)
      S_GND_GO: cmd = rot_cmd(in_q[15:0], in_q[31:16]);
      S_AIR_GO: cmd = rot_cmd(in_q[47:32], in_q[63:48]);
      S_WND_GO: begin
        cmd.start = !wind_zero;
        cmd.vec   = 1'b1;
        cmd.x     = $signed({{3{dn[19]}}, dn, 11'b0});
        cmd.y     = $signed({{3{de[19]}}, de, 11'b0});
        cmd.z     = '0;
        if (dn[19]) begin
          cmd.x = -$signed({{3{dn[19]}}, dn, 11'b0});
          cmd.y = -$signed({{3{de[19]}}, de, 11'b0});
          cmd.z = Z_HALF_TURN;
        end
      end
      default: cmd = '0;
    endcase
  end

  // Round scaled products back to components, direction and magnitude
  always_comb begin
    rnd_n   = rsp.px + (PW'(1) <<< 43);
    rnd_e   = rsp.py + (PW'(1) <<< 43);
    rnd_m   = rsp.px + (PW'(1) <<< 41);
    dir_rnd = rsp.z + Z_ROUND_16;
    if (rnd_m[PW-1]) begin
      mag_sat = '0;
    end else if (|rnd_m[PW-2:58]) begin
      mag_sat = 16'hFFFF;
    end else begin
      mag_sat = rnd_m[57:42];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (in_acc) state_d = S_GND_GO;
      S_GND_GO:  state_d = S_GND_RUN;
      S_GND_RUN: if (rsp.done) state_d = S_AIR_GO;
      S_AIR_GO:  state_d = S_AIR_RUN;
      S_AIR_RUN: if (rsp.done) state_d = S_WND_GO;
      S_WND_GO:  state_d = wind_zero ? S_PUSH : S_WND_RUN;
      S_WND_RUN: if (rsp.done) state_d = S_PUSH;
      S_PUSH:    if (push) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Control and stored state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      prev_gn_q   <= '0;
      prev_ge_q   <= '0;
      prev_an_q   <= '0;
      prev_ae_q   <= '0;
    end else begin
      state_q <= state_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_WND_GO) begin
        prev_gn_q <= cur_gn_q;
        prev_ge_q <= cur_ge_q;
        prev_an_q <= cur_an_q;
        prev_ae_q <= cur_ae_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= s_axis_tdata_i;
    end
    if (state_q == S_GND_RUN && rsp.done) begin
      cur_gn_q <= rnd_n[61:44];
      cur_ge_q <= rnd_e[61:44];
    end
    if (state_q == S_AIR_RUN && rsp.done) begin
      cur_an_q <= rnd_n[61:44];
      cur_ae_q <= rnd_e[61:44];
    end
    if (state_q == S_WND_GO && wind_zero) begin
      dir_q <= '0;
      mag_q <= '0;
    end
    if (state_q == S_WND_RUN && rsp.done) begin
      dir_q <= dir_rnd[31:16];
      mag_q <= mag_sat;
    end
    if (push) begin
      out_data_q <= {mag_q, dir_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef SYNTHESIS
  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> (state_q == S_GND_RUN || state_q == S_AIR_RUN || state_q == S_WND_RUN))
    else $error("CORDIC response outside a run state");
  a_start_in_go: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |-> (state_q == S_GND_GO || state_q == S_AIR_GO || state_q == S_WND_GO))
    else $error("CORDIC start outside a launch state");
  a_accept_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_GND_GO)
    else $error("accepted word did not launch ground pass");
  a_push_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == S_PUSH))
    else $error("output valid raised without a finished word");
`endif

endmodule

### tb/sv/wind_vector_estimator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wind_vector_estimator_tb: self-checking regression for the wind estimator
// Streams ground/air samples into the block with random idle cycles on both
// sides. A scoreboard resolves each accepted sample into north/east parts,
// forms the averaged wind vector and predicts direction and magnitude. It
// then compares every returned word field by field, in order.
// ----------------------------------------------------------------------------
module wind_vector_estimator_tb;

  localparam int unsigned STEPS       = 16;
  localparam int unsigned N_ITER      = (STEPS > 24) ? 24 : STEPS;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned DRAIN_WAIT  = 100;
  localparam int unsigned N_RANDOM    = 1430;
  localparam longint      INV_GAIN    = 64'sd652032874;
  localparam bit [31:0]   Z_HALF      = 32'h8000_0000;

  // atan(2^-i), 2^32 units per turn
  localparam bit [31:0] ATAN_Z [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic [15:0] magnitude;
    logic [15:0] direction;
  } wind_t;

  // Wind predictor and in-order result check
  class wind_checker;
    logic signed [17:0] prev_gn, prev_ge, prev_an, prev_ae;
    wind_t              due[$];
    int                 errors, samples, results, calm, saturated;

    function new();
      prev_gn = '0;
      prev_ge = '0;
      prev_an = '0;
      prev_ae = '0;
      errors = 0;
      samples = 0;
      results = 0;
      calm = 0;
      saturated = 0;
    endfunction

    // Turn a speed/angle pair into north and east parts (rotation CORDIC)
    function void resolve(input logic [15:0] speed, input logic [15:0] angle,
                          output logic signed [17:0] north,
                          output logic signed [17:0] east);
      longint      s, x, y, z, dx, dy, r;
      int unsigned q, a;
      a = angle;
      q = ((a + 8192) >> 14) & 3;
      r = longint'((a - q * 16384) & 32'hFFFF);
      if (r >= 32768) r -= 65536;
      s = longint'(speed) * 16384;
      case (q)
        0: begin x = s; y = 0; end
        1: begin x = 0; y = s; end
        2: begin x = -s; y = 0; end
        default: begin x = 0; y = -s; end
      endcase
      z = r * 65536;
      for (int i = 0; i < N_ITER; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(ATAN_Z[i]);
        end else begin
          x += dx; y -= dy; z += longint'(ATAN_Z[i]);
        end
      end
      north = 18'((x * INV_GAIN + (longint'(1) <<< 43)) >>> 44);
      east  = 18'((y * INV_GAIN + (longint'(1) <<< 43)) >>> 44);
    endfunction

    // Averaged ground-minus-air vector to direction and magnitude
    function wind_t estimate_wind(input logic [63:0] w);
      logic signed [17:0] gn, ge, an, ae;
      longint             dn, de, x, y, dx, dy, m;
      bit [31:0]          z, zr;
      wind_t              res;
      resolve(w[15:0], w[31:16], gn, ge);
      resolve(w[47:32], w[63:48], an, ae);
      dn = (longint'(gn) + longint'(prev_gn)) - (longint'(an) + longint'(prev_an));
      de = (longint'(ge) + longint'(prev_ge)) - (longint'(ae) + longint'(prev_ae));
      res = '0;
      z = '0;
      // zero wind vector leaves direction and magnitude at zero
      if (dn != 0 || de != 0) begin
        x = dn * 2048;
        y = de * 2048;
        // fold the southern half plane onto the northern one
        if (x < 0) begin
          x = -x; y = -y; z = Z_HALF;
        end
        for (int i = 0; i < N_ITER; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (y >= 0) begin
            x += dx; y -= dy; z += ATAN_Z[i];
          end else begin
            x -= dx; y += dy; z -= ATAN_Z[i];
          end
        end
        zr = z + 32'h0000_8000;
        res.direction = zr[31:16];
        m = (x * INV_GAIN + (longint'(1) <<< 41)) >>> 42;
        if (m < 0) m = 0;
        if (m > 65535) m = 65535;
        res.magnitude = m[15:0];
      end
      prev_gn = gn;
      prev_ge = ge;
      prev_an = an;
      prev_ae = ae;
      return res;
    endfunction

    function void take_sample(input logic [63:0] w);
      wind_t res;
      res = estimate_wind(w);
      samples++;
      if (res == '0) calm++;
      if (res.magnitude == 16'hFFFF) saturated++;
      due.push_back(res);
    endfunction

    function void check_wind(input logic [31:0] d);
      wind_t want;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual dir %h mag %h",
                 $time, d[15:0], d[31:16]);
        return;
      end
      want = due.pop_front();
      results++;
      if (d[15:0] !== want.direction) begin
        errors++;
        $display("%0t: wind_direction mismatch, expected %h actual %h",
                 $time, want.direction, d[15:0]);
      end
      if (d[31:16] !== want.magnitude) begin
        errors++;
        $display("%0t: wind_magnitude mismatch, expected %h actual %h",
                 $time, want.magnitude, d[31:16]);
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // ground_speed[15:0], ground_track[31:16], air_speed[47:32], air_heading[63:48]
  logic [63:0] s_axis_tdata_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // wind_direction[15:0], wind_magnitude[31:16]
  logic [31:0] m_axis_tdata_o;

  wind_checker sb;
  bit          send_burst = 1'b0;
  bit          recv_burst = 1'b0;
  int unsigned quiet      = 0;

  wind_vector_estimator #(
    .CORDIC_STEPS(STEPS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // Clock generation
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Stop the run when no word moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet);
      $display("wind_vector_estimator regression: fail");
      $finish;
    end
  end

  // Result side: random stall before each word, sometimes none
  initial begin : result_side
    int gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = recv_burst ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      sb.check_wind(m_axis_tdata_o);
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      @(negedge clk_i);
    end
  end

  // Offer one sample word after a random gap and hold it until accepted
  task automatic send_sample(input logic [15:0] gs, input logic [15:0] gt,
                             input logic [15:0] as, input logic [15:0] ah);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {ah, as, gt, gs};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.take_sample({ah, as, gt, gs});
    if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
    @(negedge clk_i);
  endtask

  // Hold off the sender until every predicted word has come back
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] edge_value();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'd8191;
      3: return 16'd8192;
      4: return 16'd16384;
      5: return 16'd32768;
      6: return 16'd49152;
      7: return 16'd24575;
      8: return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random samples of several kinds
  task automatic random_samples(input int n);
    logic [15:0] gs, gt, as, ah;
    int          k, kind;
    k = 0;
    while (k < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        // anything goes
        send_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        k++;
      end else if (kind < 72) begin
        // light wind: air vector close to ground vector
        gs = 16'($urandom);
        gt = 16'($urandom);
        as = gs + 16'($urandom_range(0, 400)) - 16'd200;
        ah = gt + 16'($urandom_range(0, 1000)) - 16'd500;
        send_sample(gs, gt, as, ah);
        k++;
      end else if (kind < 82) begin
        // calm pair: identical vectors twice give zero wind
        gs = 16'($urandom);
        gt = 16'($urandom);
        send_sample(gs, gt, gs, gt);
        send_sample(gs, gt, gs, gt);
        k += 2;
      end else if (kind < 94) begin
        send_sample(edge_value(), edge_value(), edge_value(), edge_value());
        k++;
      end else begin
        // slow speeds, where rounding dominates
        send_sample(16'($urandom_range(0, 15)), 16'($urandom),
                    16'($urandom_range(0, 15)), 16'($urandom));
        k++;
      end
      if (k % 300 < 2 && k > 2) drain();
    end
  endtask

  // Main sequence
  initial begin
    sb = new();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // zero wind from all-zero samples
    send_sample(16'd0, 16'd0, 16'd0, 16'd0);
    send_sample(16'd0, 16'd0, 16'd0, 16'd0);
    // full ground speed north, no air
    send_sample(16'hFFFF, 16'd0, 16'd0, 16'd0);
    send_sample(16'hFFFF, 16'd0, 16'd0, 16'd0);
    // opposing full vectors saturate the magnitude
    send_sample(16'hFFFF, 16'd0, 16'hFFFF, 16'd32768);
    send_sample(16'hFFFF, 16'd0, 16'hFFFF, 16'd32768);
    // wind toward the south, negative north part
    send_sample(16'hFFFF, 16'd32768, 16'd0, 16'd0);
    send_sample(16'd5000, 16'd32768, 16'd100, 16'd0);
    // east and west winds
    send_sample(16'd3000, 16'd16384, 16'd0, 16'd0);
    send_sample(16'd3000, 16'd49152, 16'd0, 16'd0);
    // quarter-turn rounding boundaries of the track angle
    send_sample(16'd20000, 16'd8191, 16'd1000, 16'd8192);
    send_sample(16'd20000, 16'd24575, 16'd1000, 16'd24576);
    send_sample(16'd20000, 16'd40959, 16'd1000, 16'd40960);
    send_sample(16'd20000, 16'd57343, 16'd1000, 16'd57344);
    send_sample(16'd20000, 16'hFFFF, 16'd1000, 16'd1);
    // identical ground and air vectors twice give zero wind again
    send_sample(16'd1000, 16'd12345, 16'd1000, 16'd12345);
    send_sample(16'd1000, 16'd12345, 16'd1000, 16'd12345);
    // all fields at top and minimal speeds
    send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(16'd1, 16'd0, 16'd0, 16'd0);
    send_sample(16'd1, 16'd0, 16'd0, 16'd0);
    send_sample(16'd0, 16'd0, 16'd1, 16'd32768);
    send_sample(16'hFFFF, 16'd16384, 16'hFFFF, 16'd49152);
    drain();

    random_samples(N_RANDOM);

    // let everything come back, then watch for stray words
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Checked %0d wind words from %0d samples: %0d calm, %0d saturated.",
             sb.results, sb.samples, sb.calm, sb.saturated);
    $display("Errors found: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("wind_vector_estimator regression: pass");
    end else begin
      $display("wind_vector_estimator regression: fail");
    end
    $finish;
  end

endmodule
